@@ hdl/tkcv_pkg.sv @@
// Package for the top-K critical value tracker: widths, codes, state encoding
// and the reciprocal constants used for exact division by fixed divisors.
// No dependencies.
package tkcv_pkg;

   // List storage
   localparam int ENTRY_COUNT = 256;
   localparam int ADDR_W      = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
   localparam int CNT_W       = $clog2(ENTRY_COUNT + 1);

   // Field widths
   localparam int DATA_W  = 32;
   localparam int NREP_W  = 13;
   localparam int OP_W    = 2;
   localparam int LEVEL_W = 3;

   // Reciprocal divider: dividend up to N+20 fits in 14 bits
   localparam int DIVIDEND_W = NREP_W + 1;
   localparam int RECIP_W    = 32;
   localparam int QUOT_W     = DIVIDEND_W;
   localparam int RECIP_SHIFT = 32;

   localparam logic [NREP_W-1:0] NREP_RESET = NREP_W'(999);

   // K = ceil((N+1)/20) = floor((N+20)/20)
   localparam logic [DIVIDEND_W-1:0] K_BIAS = DIVIDEND_W'(20);

   // ceil(2^32 / d) for each fixed divisor
   localparam logic [RECIP_W-1:0] RECIP_D20     = 32'd214748365;
   localparam logic [RECIP_W-1:0] RECIP_D100    = 32'd42949673;
   localparam logic [RECIP_W-1:0] RECIP_D1000   = 32'd4294968;
   localparam logic [RECIP_W-1:0] RECIP_D10000  = 32'd429497;
   localparam logic [RECIP_W-1:0] RECIP_D100000 = 32'd42950;

   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic [NREP_W-1:0]        nrep_type;
   typedef logic [LEVEL_W-1:0]       level_type;

   typedef enum logic [OP_W-1:0] {
      OP_ADD   = 2'd0,
      OP_CLEAR = 2'd1,
      OP_QUERY = 2'd2
   } op_type;

   // Significance levels
   localparam level_type LEVEL_P01     = 3'd0;
   localparam level_type LEVEL_P05     = 3'd1;
   localparam level_type LEVEL_P001    = 3'd2;
   localparam level_type LEVEL_P0001   = 3'd3;
   localparam level_type LEVEL_P00001  = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_KDIV,
      ST_KTAKE,
      ST_WALK_RD,
      ST_WALK_CMP,
      ST_QTAKE,
      ST_QDATA,
      ST_DONE
   } state_type;

   // Reciprocal for the divisor of a level; zero for unknown levels
   function automatic logic [RECIP_W-1:0] level_recip(input level_type level);
      logic [RECIP_W-1:0] r;
      unique case (level)
         LEVEL_P01:    r = RECIP_D100;
         LEVEL_P05:    r = RECIP_D20;
         LEVEL_P001:   r = RECIP_D1000;
         LEVEL_P0001:  r = RECIP_D10000;
         LEVEL_P00001: r = RECIP_D100000;
         default:      r = '0;
      endcase
      return r;
   endfunction

   function automatic logic level_known(input level_type level);
      return (level <= LEVEL_P00001);
   endfunction

endpackage

@@ hdl/tkcv_if.sv @@
// Channel interfaces of the top-K critical value tracker: request, response
// and configuration write. Depends on tkcv_pkg.

interface tkcv_req_if;
   logic                               valid;
   logic                               ready;
   logic [tkcv_pkg::OP_W-1:0]          opcode;
   logic signed [tkcv_pkg::DATA_W-1:0] value;
   logic [tkcv_pkg::LEVEL_W-1:0]       level;

   modport source (output valid, output opcode, output value, output level, input ready);
   modport sink   (input valid, input opcode, input value, input level, output ready);
endinterface

interface tkcv_rsp_if;
   logic                               valid;
   logic                               ready;
   logic                               accepted;
   logic                               crit_valid;
   logic signed [tkcv_pkg::DATA_W-1:0] crit_value;

   modport source (output valid, output accepted, output crit_valid, output crit_value,
                   input ready);
   modport sink   (input valid, input accepted, input crit_valid, input crit_value,
                   output ready);
endinterface

interface tkcv_csr_if;
   logic                         valid;
   logic                         ready;
   logic [tkcv_pkg::NREP_W-1:0]  data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/tkcv_recip_div.sv @@
// Shared constant divider: quotient = floor(dividend * recip / 2^32), one
// registered multiply. Depends on tkcv_pkg.
module tkcv_recip_div (
   input  logic                             clock,
   input  logic [tkcv_pkg::DIVIDEND_W-1:0]  dividend,
   input  logic [tkcv_pkg::RECIP_W-1:0]     recip,
   output logic [tkcv_pkg::QUOT_W-1:0]      quotient
);
   import tkcv_pkg::*;

   localparam int PROD_W = DIVIDEND_W + RECIP_W;

   logic [PROD_W-1:0] prod;
   logic [QUOT_W-1:0] quot_ff;
   logic [QUOT_W-1:0] quot_in;

   // Multiply by the reciprocal and keep the integer part
   assign prod    = PROD_W'(dividend) * PROD_W'(recip);
   assign quot_in = prod[RECIP_SHIFT +: QUOT_W];

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
   end

   assign quotient = quot_ff;

endmodule

@@ hdl/top_k_critical_value_tracker.sv @@
// Top level of the top-K critical value tracker: sequencer, ranked list memory
// and response register. Depends on tkcv_pkg, tkcv_if and tkcv_recip_div.
//
// Usage:
//   req_ch carries one command per transfer: add a value, clear the list, or
//   query the critical value for a significance level. Every command gives
//   exactly one transfer on rsp_ch. csr_ch writes the replication count N;
//   a write also empties the list. Write it only while no command is pending.
//   The list holds K = ceil((N+1)/20) entries (at most 256) in descending
//   signed order.
// Command flow:
//   req_ch.ready is high only in idle; one command is worked at a time.
//   Each command passes KDIV and KTAKE. An add then walks all K entries,
//   reading each in WALK_RD, comparing it and, from the insert point on,
//   writing it in WALK_CMP. Clear and unknown opcodes go on to DONE; a query
//   passes QTAKE and QDATA, or skips QDATA when the rank does not exist.
//   Both K and the query rank come from one shared reciprocal multiplier, one product per cycle.
// Reset and stall:
//   reset sets N to 999 and empties the list through per-entry valid bits.
//   The response sits in an output register; a new command is taken while
//   it waits, and that command's result holds in the sequencer until
//   rsp_ch.ready frees the register.
module top_k_critical_value_tracker (
   input  logic       clock,
   input  logic       reset,
   tkcv_req_if.sink   req_ch,
   tkcv_rsp_if.source rsp_ch,
   tkcv_csr_if.sink   csr_ch
);
   import tkcv_pkg::*;

   // Control state
   state_type              state_ff, state_in;
   nrep_type               nrep_ff, nrep_in;
   logic [CNT_W-1:0]       k_ff, k_in;
   logic [ADDR_W-1:0]      idx_ff, idx_in;
   logic                   inserted_ff, inserted_in;
   logic [ENTRY_COUNT-1:0] valid_ff, valid_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // Command and result payload
   op_type                 op_ff, op_in;
   data_type               carry_ff, carry_in;
   level_type              level_ff, level_in;
   logic                   res_acc_ff, res_acc_in;
   logic                   res_cv_ff, res_cv_in;
   data_type               res_val_ff, res_val_in;
   logic                   rsp_acc_ff, rsp_acc_in;
   logic                   rsp_cv_ff, rsp_cv_in;
   data_type               rsp_val_ff, rsp_val_in;

   // List memory
   data_type               list_mem_ff [ENTRY_COUNT];
   data_type               rd_data_ff;
   logic                   rd_vld_ff;
   logic [ADDR_W-1:0]      rd_addr;
   logic                   wr_en;
   data_type               entry;

   // Divider
   logic [DIVIDEND_W-1:0]  div_dividend;
   logic [RECIP_W-1:0]     div_recip;
   logic [QUOT_W-1:0]      div_quot;
   logic [QUOT_W-1:0]      rank_q;
   logic                   rank_ok;

   logic                   req_xfer;
   logic                   csr_xfer;
   logic                   rsp_free;

   tkcv_recip_div u_div (
      .clock    (clock),
      .dividend (div_dividend),
      .recip    (div_recip),
      .quotient (div_quot)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = (state_ff == ST_IDLE);
   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign csr_xfer     = csr_ch.valid && csr_ch.ready;
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;

   // Entry just read; an entry not valid since the last clear or reset reads as zero
   assign entry  = rd_vld_ff ? rd_data_ff : '0;
   assign rank_q = div_quot - QUOT_W'(1);
   assign rank_ok = level_known(level_ff) && (div_quot != '0) &&
                    (rank_q < QUOT_W'(k_ff));

   // Sequencer: next state and datapath controls
   always_comb begin
      state_in     = state_ff;
      nrep_in      = nrep_ff;
      k_in         = k_ff;
      idx_in       = idx_ff;
      inserted_in  = inserted_ff;
      valid_in     = valid_ff;
      op_in        = op_ff;
      carry_in     = carry_ff;
      level_in     = level_ff;
      res_acc_in   = res_acc_ff;
      res_cv_in    = res_cv_ff;
      res_val_in   = res_val_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_acc_in   = rsp_acc_ff;
      rsp_cv_in    = rsp_cv_ff;
      rsp_val_in   = rsp_val_ff;
      rd_addr      = idx_ff;
      wr_en        = 1'b0;
      div_dividend = DIVIDEND_W'(nrep_ff) + K_BIAS;
      div_recip    = RECIP_D20;

      unique case (state_ff)
         ST_IDLE: begin
            if (csr_xfer) begin
               nrep_in  = csr_ch.data;
               valid_in = '0;
            end
            if (req_xfer) begin
               op_in       = op_type'(req_ch.opcode);
               carry_in    = req_ch.value;
               level_in    = req_ch.level;
               res_acc_in  = 1'b0;
               res_cv_in   = 1'b0;
               res_val_in  = '0;
               state_in    = ST_KDIV;
            end
         end
         ST_KDIV: begin
            // K product in flight
            state_in = ST_KTAKE;
         end
         ST_KTAKE: begin
            // Cap K and start the rank product
            k_in = (div_quot > QUOT_W'(ENTRY_COUNT)) ? CNT_W'(ENTRY_COUNT)
                                                     : div_quot[CNT_W-1:0];
            div_dividend = DIVIDEND_W'(nrep_ff) + DIVIDEND_W'(1);
            div_recip    = level_recip(level_ff);
            idx_in       = '0;
            inserted_in  = 1'b0;
            case (op_ff)
               OP_ADD:   state_in = ST_WALK_RD;
               OP_QUERY: state_in = ST_QTAKE;
               OP_CLEAR: begin
                  valid_in = '0;
                  state_in = ST_DONE;
               end
               default:  state_in = ST_DONE;
            endcase
         end
         ST_WALK_RD: begin
            state_in = ST_WALK_CMP;
         end
         ST_WALK_CMP: begin
            // Insert at the first smaller entry, then ripple the rest down
            if (inserted_ff || (carry_ff > entry)) begin
               wr_en          = 1'b1;
               valid_in[idx_ff] = 1'b1;
               carry_in       = entry;
               inserted_in    = 1'b1;
               res_acc_in     = 1'b1;
            end
            if ((CNT_W'(idx_ff) + CNT_W'(1)) == k_ff) begin
               state_in = ST_DONE;
            end else begin
               idx_in   = idx_ff + ADDR_W'(1);
               state_in = ST_WALK_RD;
            end
         end
         ST_QTAKE: begin
            rd_addr = rank_q[ADDR_W-1:0];
            if (rank_ok) begin
               state_in = ST_QDATA;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_QDATA: begin
            res_cv_in  = 1'b1;
            res_val_in = entry;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            // Hand the result over once the output register is free
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_acc_in   = res_acc_ff;
               rsp_cv_in    = res_cv_ff;
               rsp_val_in   = res_val_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         nrep_ff      <= NREP_RESET;
         k_ff         <= '0;
         idx_ff       <= '0;
         inserted_ff  <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         nrep_ff      <= nrep_in;
         k_ff         <= k_in;
         idx_ff       <= idx_in;
         inserted_ff  <= inserted_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      carry_ff   <= carry_in;
      level_ff   <= level_in;
      res_acc_ff <= res_acc_in;
      res_cv_ff  <= res_cv_in;
      res_val_ff <= res_val_in;
      rsp_acc_ff <= rsp_acc_in;
      rsp_cv_ff  <= rsp_cv_in;
      rsp_val_ff <= rsp_val_in;
   end

   // List memory: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         list_mem_ff[idx_ff] <= carry_ff;
      end
      rd_data_ff <= list_mem_ff[rd_addr];
      rd_vld_ff  <= valid_ff[rd_addr];
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.accepted   = rsp_acc_ff;
   assign rsp_ch.crit_valid = rsp_cv_ff;
   assign rsp_ch.crit_value = rsp_val_ff;

   // Checks
   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> !(rsp_ch.accepted && rsp_ch.crit_valid))
      else $error("accepted and crit_valid both set");

   a_zero_when_invalid: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.crit_valid) |-> (rsp_ch.crit_value == '0))
      else $error("crit_value nonzero without crit_valid");

   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK_CMP) |-> (CNT_W'(idx_ff) < k_ff))
      else $error("walk index past active length");

   a_csr_clears: assert property (@(posedge clock) disable iff (reset)
      csr_xfer |=> (valid_ff == '0))
      else $error("list not emptied by configuration write");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req_ch.ready)
      else $error("request taken while a command is in work");

endmodule
